@@ rtl/tkpc_pkg.sv @@
// shared types and constants for the three-key press classifier
// no dependencies; imported by every module in rtl/

package tkpc_pkg;

    localparam int TICK_W = 10;
    localparam int THR_W  = 16;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam int NUM_KEYS = 3;

    // register indexes (byte address is 4 times the index)
    localparam logic [1:0] REG_TICK_MS      = 2'd0;
    localparam logic [1:0] REG_SHORT_MIN_MS = 2'd1;
    localparam logic [1:0] REG_LONG_MIN_MS  = 2'd2;
    localparam logic [1:0] REG_LONG_MAX_MS  = 2'd3;

    // register reset values
    localparam logic [TICK_W-1:0] RST_TICK_MS      = 10'd10;
    localparam logic [THR_W-1:0]  RST_SHORT_MIN_MS = 16'd100;
    localparam logic [THR_W-1:0]  RST_LONG_MIN_MS  = 16'd1500;
    localparam logic [THR_W-1:0]  RST_LONG_MAX_MS  = 16'd3000;

    // setting option codes and blink time
    localparam logic [1:0] OPT_TIMER = 2'd3;
    localparam logic [1:0] OPT_NONE  = 2'd0;
    localparam logic [2:0] BLINK_SECS = 3'd6;
    localparam logic [2:0] BLINK_NONE = 3'd0;

    typedef struct packed {
        logic [TICK_W-1:0] tick_ms;
        logic [THR_W-1:0]  short_min_ms;
        logic [THR_W-1:0]  long_min_ms;
        logic [THR_W-1:0]  long_max_ms;
    } cfg_t;

    // per-key outcome of one tick plus its current marks
    typedef struct packed {
        logic click;
        logic dbl;
        logic pressed;
        logic long_mark;
    } key_stat_t;

endpackage

@@ rtl/tkpc_regs.sv @@
// apb-style configuration registers: tick period and press thresholds
// depends on tkpc_pkg

module tkpc_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tkpc_pkg::ADDR_W-1:0] paddr,
    input  logic [tkpc_pkg::DATA_W-1:0] pwdata,
    output logic [tkpc_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output tkpc_pkg::cfg_t              cfg
);
    import tkpc_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] idx;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tick_ms      <= RST_TICK_MS;
            cfg_reg.short_min_ms <= RST_SHORT_MIN_MS;
            cfg_reg.long_min_ms  <= RST_LONG_MIN_MS;
            cfg_reg.long_max_ms  <= RST_LONG_MAX_MS;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_TICK_MS:      cfg_reg.tick_ms      <= pwdata[TICK_W-1:0];
                REG_SHORT_MIN_MS: cfg_reg.short_min_ms <= pwdata[THR_W-1:0];
                REG_LONG_MIN_MS:  cfg_reg.long_min_ms  <= pwdata[THR_W-1:0];
                REG_LONG_MAX_MS:  cfg_reg.long_max_ms  <= pwdata[THR_W-1:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_TICK_MS:      prdata[TICK_W-1:0] = cfg_reg.tick_ms;
            REG_SHORT_MIN_MS: prdata[THR_W-1:0]  = cfg_reg.short_min_ms;
            REG_LONG_MIN_MS:  prdata[THR_W-1:0]  = cfg_reg.long_min_ms;
            REG_LONG_MAX_MS:  prdata[THR_W-1:0]  = cfg_reg.long_max_ms;
            default:          prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/tkpc_key.sv @@
// one key's press timer, pressed mark and long-press mark
// depends on tkpc_pkg; instantiated once per key by the top level

module tkpc_key #(
    parameter int TIMER_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 down,
    input  tkpc_pkg::cfg_t       cfg,
    output tkpc_pkg::key_stat_t  stat
);
    import tkpc_pkg::*;

    localparam int SW = ((TIMER_BITS > TICK_W) ? TIMER_BITS : TICK_W) + 1;
    localparam int CW = (TIMER_BITS > THR_W) ? TIMER_BITS : THR_W;
    localparam logic [SW-1:0] TMAX = SW'((64'd1 << TIMER_BITS) - 64'd1);

    logic [TIMER_BITS-1:0] timer_reg, timer_next, t1;
    logic                  pressed_reg, pressed_next;
    logic                  long_reg, long_next;
    logic [SW-1:0]         sum;
    logic [CW-1:0]         t1_c, t2_c, smin_c, lmin_c, lmax_c;
    logic                  grow, p1, click, dbl;

    assign sum    = SW'(timer_reg) + SW'(cfg.tick_ms);
    assign grow   = down && !long_reg;
    assign t1     = !grow ? timer_reg
                  : (sum > TMAX) ? TMAX[TIMER_BITS-1:0] : sum[TIMER_BITS-1:0];
    assign p1     = grow || pressed_reg;
    assign t1_c   = CW'(t1);
    assign smin_c = CW'(cfg.short_min_ms);
    assign lmin_c = CW'(cfg.long_min_ms);
    assign lmax_c = CW'(cfg.long_max_ms);

    always_comb
    begin
        click        = 1'b0;
        dbl          = 1'b0;
        timer_next   = t1;
        pressed_next = p1;
        long_next    = long_reg;
        if (p1 && !down)
        begin
            // release: classify then clear everything
            click        = (t1_c > smin_c) && (t1_c < lmin_c);
            timer_next   = '0;
            pressed_next = 1'b0;
            long_next    = 1'b0;
        end
        t2_c = CW'(timer_next);
        if (p1 && (t2_c > lmin_c) && (t2_c < lmax_c) && !long_next)
        begin
            dbl       = 1'b1;
            long_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_reg   <= '0;
            pressed_reg <= 1'b0;
            long_reg    <= 1'b0;
        end
        else if (en)
        begin
            timer_reg   <= timer_next;
            pressed_reg <= pressed_next;
            long_reg    <= long_next;
        end
    end

    assign stat.click     = click;
    assign stat.dbl       = dbl;
    assign stat.pressed   = pressed_reg;
    assign stat.long_mark = long_reg;

endmodule

@@ rtl/three_key_press_classifier_top.sv @@
// top level of the three-key press classifier: input register, three key
// units, event merge and result register; depends on tkpc_pkg, tkpc_regs, tkpc_key
//
//  channel   direction  handshake               payload
//  s_*       in         s_tvalid / s_tready     s_tdata: one scan tick (key levels, option)
//  m_*       out        m_tvalid / m_tready     m_tdata: one result per tick
//  apb       in/out     psel, penable, pready   4 registers at byte addresses 0, 4, 8, 12
//
// one tick per cycle sustained while m_tready keeps up; a request passes the input register, then the result register
// the key timers update as a tick leaves the input register, so ticks are
// processed strictly in order with one tick of state feedback per cycle
// reset (rst_n low, async) clears timers, marks, lock state and both valid flags
// a stalled result holds the result register; the input register still takes
// a new request while the result register drains

module three_key_press_classifier_top #(
    parameter int TIMER_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // tick requests
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,  // lock_key_down, timer_key_down,
                                                  // reverse_key_down, option_now[1:0],
                                                  // reversal_active, 2 bits zero
    // results
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata,  // locked, beep_short, beep_double,
                                                  // option_write, option_value[1:0],
                                                  // blink_seconds[2:0], enter_time_set,
                                                  // reverse_start, 5 bits zero
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tkpc_pkg::ADDR_W-1:0] paddr,
    input  logic [tkpc_pkg::DATA_W-1:0] pwdata,
    output logic [tkpc_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import tkpc_pkg::*;

    cfg_t       cfg;
    key_stat_t  stat [NUM_KEYS];

    // input register
    logic       in_valid_reg;
    logic [NUM_KEYS-1:0] keys_reg;
    logic [1:0] opt_reg;
    logic       busy_reg;

    // result register
    logic       out_valid_reg;
    logic [10:0] res_reg, res_next;

    logic       lock_reg, lock_next;
    logic       advance;
    logic       lock_ok;
    logic       opt_click, rev_click;

    // move a tick forward whenever the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    tkpc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_key
        tkpc_key #(
            .TIMER_BITS (TIMER_BITS)
        ) u_key (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (advance),
            .down  (keys_reg[k]),
            .cfg   (cfg),
            .stat  (stat[k])
        );
    end

    // lock key first; its toggle is seen by the other two keys in the same tick
    assign lock_next = lock_reg ^ stat[0].click;
    assign lock_ok   = !lock_next;
    assign opt_click = stat[1].click && lock_ok;
    assign rev_click = stat[2].click && lock_ok;

    always_comb
    begin
        res_next     = '0;
        res_next[0]  = lock_next;
        res_next[1]  = stat[0].click || opt_click || rev_click;
        // long press on any key, or a click refused by the lock
        res_next[2]  = stat[0].dbl || stat[1].dbl || stat[2].dbl
                    || ((stat[1].click || stat[2].click) && !lock_ok);
        res_next[3]  = opt_click;
        if (opt_click && (opt_reg != OPT_TIMER))
        begin
            res_next[5:4] = OPT_TIMER;
            res_next[8:6] = BLINK_SECS;
        end
        else
        begin
            res_next[5:4] = OPT_NONE;
            res_next[8:6] = BLINK_NONE;
        end
        res_next[9]  = opt_click && (opt_reg == OPT_TIMER);
        res_next[10] = rev_click && !busy_reg;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            lock_reg      <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                lock_reg      <= lock_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            keys_reg <= s_tdata[2:0];
            opt_reg  <= s_tdata[4:3];
            busy_reg <= s_tdata[5];
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, res_reg};

`ifndef SYNTHESIS
    // entering time setting only comes with an option write of zero
    a_ets_write: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[9] |-> m_tdata[3] && (m_tdata[5:4] == OPT_NONE))
        else $error("enter_time_set without option write of zero");

    // a reversal start is an accepted click: unlocked and with a short beep
    a_rev_unlocked: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[10] |-> m_tdata[1] && !m_tdata[0])
        else $error("reverse_start while locked or without beep");

    // a long-press mark lives only inside a press
    a_long_in_press: assert property (@(posedge clk) disable iff (!rst_n)
        (!stat[0].long_mark || stat[0].pressed)
        && (!stat[1].long_mark || stat[1].pressed)
        && (!stat[2].long_mark || stat[2].pressed))
        else $error("long mark set on a released key");

    // a tick that is not moved forward keeps the input register full
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(keys_reg))
        else $error("stalled tick lost");
`endif

endmodule

@@ sim/press_event_checker.sv @@
// checker for the three-key press classifier: follows register writes, predicts
// one result per accepted tick and compares it with the result stream
// depends on tkpc_pkg
`timescale 1ns / 1ps

module press_event_checker #(
    parameter int TIMER_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [7:0]                  s_tdata,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [15:0]                 m_tdata,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [tkpc_pkg::ADDR_W-1:0] paddr,
    input  logic [tkpc_pkg::DATA_W-1:0] pwdata,
    output int                          mismatches,
    output int                          in_flight
);

    import tkpc_pkg::*;

    typedef struct packed {
        logic       locked;
        logic       beep_short;
        logic       beep_double;
        logic       option_write;
        logic [1:0] option_value;
        logic [2:0] blink_seconds;
        logic       enter_time_set;
        logic       reverse_start;
    } press_result_t;

    press_result_t result_q[$];

    logic [TICK_W-1:0]     tick_ms_r;
    logic [THR_W-1:0]      short_min_r;
    logic [THR_W-1:0]      long_min_r;
    logic [THR_W-1:0]      long_max_r;
    logic [TIMER_BITS-1:0] press_ms [NUM_KEYS];
    logic                  held [NUM_KEYS];
    logic                  long_seen [NUM_KEYS];
    logic                  lock_on;
    int                    mismatch_cnt = 0;

    assign mismatches = mismatch_cnt;

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_cnt++;
        $display("%0t ns mismatch: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // one key for one tick; dbl is ORed across keys
    task automatic advance_key(input int k, input logic down, inout logic dbl,
                               output logic click);
        logic [32:0] sum;
        logic [32:0] tmax;
        tmax  = (33'd1 << TIMER_BITS) - 33'd1;
        click = 1'b0;
        if (down && !long_seen[k]) begin
            sum = 33'(press_ms[k]) + 33'(tick_ms_r);
            press_ms[k] = (sum > tmax) ? tmax[TIMER_BITS-1:0] : sum[TIMER_BITS-1:0];
            held[k] = 1'b1;
        end
        if (held[k]) begin
            if (!down) begin
                click        = (press_ms[k] > short_min_r) && (press_ms[k] < long_min_r);
                held[k]      = 1'b0;
                long_seen[k] = 1'b0;
                press_ms[k]  = '0;
            end
            if (press_ms[k] > long_min_r && press_ms[k] < long_max_r && !long_seen[k]) begin
                dbl          = 1'b1;
                long_seen[k] = 1'b1;
            end
        end
    endtask

    task automatic predict_tick(input logic [7:0] d, output press_result_t r);
        logic click;
        logic dbl;
        r   = '0;
        dbl = 1'b0;
        advance_key(0, d[0], dbl, click);
        if (click) begin
            lock_on      = ~lock_on;
            r.beep_short = 1'b1;
        end
        advance_key(1, d[1], dbl, click);
        if (click) begin
            if (lock_on)
                dbl = 1'b1;
            else begin
                r.option_write = 1'b1;
                r.beep_short   = 1'b1;
                if (d[4:3] != OPT_TIMER) begin
                    r.option_value  = OPT_TIMER;
                    r.blink_seconds = BLINK_SECS;
                end
                else begin
                    r.option_value   = OPT_NONE;
                    r.blink_seconds  = BLINK_NONE;
                    r.enter_time_set = 1'b1;
                end
            end
        end
        advance_key(2, d[2], dbl, click);
        if (click) begin
            if (lock_on)
                dbl = 1'b1;
            else begin
                r.reverse_start = !d[5];
                r.beep_short    = 1'b1;
            end
        end
        r.locked      = lock_on;
        r.beep_double = dbl;
    endtask

    task automatic check_result(input press_result_t got, input press_result_t want);
        if (got.locked != want.locked)
            report_mismatch("locked", got.locked, want.locked);
        if (got.beep_short != want.beep_short)
            report_mismatch("beep_short", got.beep_short, want.beep_short);
        if (got.beep_double != want.beep_double)
            report_mismatch("beep_double", got.beep_double, want.beep_double);
        if (got.option_write != want.option_write)
            report_mismatch("option_write", got.option_write, want.option_write);
        if (got.option_value != want.option_value)
            report_mismatch("option_value", got.option_value, want.option_value);
        if (got.blink_seconds != want.blink_seconds)
            report_mismatch("blink_seconds", got.blink_seconds, want.blink_seconds);
        if (got.enter_time_set != want.enter_time_set)
            report_mismatch("enter_time_set", got.enter_time_set, want.enter_time_set);
        if (got.reverse_start != want.reverse_start)
            report_mismatch("reverse_start", got.reverse_start, want.reverse_start);
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        press_result_t want;
        press_result_t got;
        if (!rst_n) begin
            tick_ms_r   = RST_TICK_MS;
            short_min_r = RST_SHORT_MIN_MS;
            long_min_r  = RST_LONG_MIN_MS;
            long_max_r  = RST_LONG_MAX_MS;
            for (int k = 0; k < NUM_KEYS; k++) begin
                press_ms[k]  = '0;
                held[k]      = 1'b0;
                long_seen[k] = 1'b0;
            end
            lock_on = 1'b0;
            result_q.delete();
            in_flight <= 0;
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_TICK_MS:      tick_ms_r   = pwdata[TICK_W-1:0];
                    REG_SHORT_MIN_MS: short_min_r = pwdata[THR_W-1:0];
                    REG_LONG_MIN_MS:  long_min_r  = pwdata[THR_W-1:0];
                    REG_LONG_MAX_MS:  long_max_r  = pwdata[THR_W-1:0];
                    default: ;
                endcase
            end
            // results leave before the tick taken at this edge can produce one
            if (m_tvalid && m_tready) begin
                if (result_q.size() == 0)
                    report_mismatch("result with no request waiting, tdata", m_tdata, 0);
                else begin
                    want                 = result_q.pop_front();
                    got.locked           = m_tdata[0];
                    got.beep_short       = m_tdata[1];
                    got.beep_double      = m_tdata[2];
                    got.option_write     = m_tdata[3];
                    got.option_value     = m_tdata[5:4];
                    got.blink_seconds    = m_tdata[8:6];
                    got.enter_time_set   = m_tdata[9];
                    got.reverse_start    = m_tdata[10];
                    check_result(got, want);
                end
            end
            if (s_tvalid && s_tready) begin
                predict_tick(s_tdata, want);
                result_q.push_back(want);
            end
            in_flight <= result_q.size();
        end
    end

endmodule

@@ sim/tb.sv @@
// testbench top for the three-key press classifier: clock, reset, register
// setup, directed and random tick requests, result stall and verdict
// depends on tkpc_pkg, three_key_press_classifier_top and press_event_checker
`timescale 1ns / 1ps

module tb;

    import tkpc_pkg::*;

    localparam int TIMER_BITS = 16;
    localparam int RUN_LIMIT  = 300000;   // cycles; far beyond the slowest correct run
    localparam int HOLD_CYCLES = 150;     // long receiver hold-off
    localparam int MAX_HOLD_TICKS = 400;

    // key masks for the request's key-level bits
    localparam logic [2:0] KEY_NONE    = 3'b000;
    localparam logic [2:0] KEY_LOCK    = 3'b001;
    localparam logic [2:0] KEY_TIMER   = 3'b010;
    localparam logic [2:0] KEY_REVERSE = 3'b100;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic [7:0]          s_tdata  = '0;   // keys[2:0], option_now[1:0], reversal_active, 2 zero
    logic                m_tready = 1'b0;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [ADDR_W-1:0]   paddr    = '0;
    logic [DATA_W-1:0]   pwdata   = '0;
    wire                 s_tready;
    wire                 m_tvalid;
    wire [15:0]          m_tdata;
    wire [DATA_W-1:0]    prdata;
    wire                 pready;
    int                  fail_count;
    int                  pending;

    // stimulus-side copy of the thresholds, only used to shape press lengths
    int cur_tick      = int'(RST_TICK_MS);
    int cur_short     = int'(RST_SHORT_MIN_MS);
    int cur_long_min  = int'(RST_LONG_MIN_MS);
    int cur_long_max  = int'(RST_LONG_MAX_MS);
    int hold_ticks [3] = '{0, 0, 0};   // remaining held ticks per key
    logic quiet       = 1'b0;          // no idling on either side while set
    int hold_asks     = 0;             // bumped to request a long receiver hold-off
    int holds_done    = 0;
    int stall_left    = 0;
    int cycle_count   = 0;

    three_key_press_classifier_top #(
        .TIMER_BITS(TIMER_BITS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    press_event_checker #(
        .TIMER_BITS(TIMER_BITS)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .mismatches (fail_count),
        .in_flight  (pending)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit: a hang or a lost result ends here
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT) begin
            $display("[three_key_press_classifier_top] ERROR");
            $finish;
        end
    end

    // result side: random stalls, a long hold-off on request, none while quiet
    always @(posedge clk)
    begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (holds_done != hold_asks) begin
            holds_done++;
            stall_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else
            m_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 22);
    end

    // one tick request; valid stays high after acceptance until the next
    // request or an idle cycle replaces it
    task automatic send_tick(input logic [2:0] keys, input logic [1:0] opt,
                             input logic busy);
        while (!quiet && $urandom_range(99) < 22) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, busy, opt, keys};
        do @(posedge clk); while (!s_tready);
    endtask

    // hold the given keys for n ticks, then one tick with every key up
    task automatic press_release(input logic [2:0] keys, input int n,
                                 input logic [1:0] opt, input logic busy);
        repeat (n) send_tick(keys, opt, busy);
        send_tick(KEY_NONE, opt, busy);
    endtask

    // every request yields one result, so no results owed means idle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // setup then access; the caller ends the transfer
    task automatic reg_write(input logic [1:0] idx, input logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    task automatic set_config(input int tick, input int short_min, input int long_min,
                              input int long_max);
        wait_idle();
        reg_write(REG_TICK_MS, tick);
        reg_write(REG_SHORT_MIN_MS, short_min);
        reg_write(REG_LONG_MIN_MS, long_min);
        reg_write(REG_LONG_MAX_MS, long_max);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_tick     = tick;
        cur_short    = short_min;
        cur_long_min = long_min;
        cur_long_max = long_max;
    endtask

    // press length in ticks, aimed around the thresholds so that clicks,
    // long presses, skipped long windows and saturation all show up
    function automatic int pick_hold();
        int target;
        int n;
        case ($urandom_range(3))
            0:       target = cur_short;
            1:       target = cur_long_min;
            2:       target = cur_long_max;
            default: target = $urandom_range(cur_long_max + 2 * cur_tick);
        endcase
        if (cur_tick == 0)
            n = $urandom_range(1, 6);
        else
            n = target / cur_tick + int'($urandom_range(0, 3)) - 1;
        if (n < 1)
            n = 1;
        if (n > MAX_HOLD_TICKS)
            n = MAX_HOLD_TICKS;
        return n;
    endfunction

    // mostly well-formed press/release runs per key, with some raw noise
    task automatic random_phase(input int count);
        logic [2:0] keys;
        for (int i = 0; i < count; i++) begin
            for (int k = 0; k < 3; k++) begin
                keys[k] = (hold_ticks[k] > 0);
                if (hold_ticks[k] > 0)
                    hold_ticks[k]--;
                else if ($urandom_range(99) < 35)
                    hold_ticks[k] = pick_hold();
            end
            if ($urandom_range(99) < 8)
                keys = 3'($urandom_range(7));
            send_tick(keys, 2'($urandom_range(3)), $urandom_range(99) < 30);
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // fast thresholds: a click is 2 to 4 held ticks, long press at 6
        set_config(100, 100, 500, 1000);

        // directed: lock toggle, locked clicks, option writes, reversal
        press_release(KEY_LOCK, 2, OPT_NONE, 1'b0);              // lock
        press_release(KEY_TIMER | KEY_REVERSE, 2, OPT_NONE, 1'b0); // double beep while locked
        press_release(KEY_LOCK, 2, 2'd2, 1'b0);                  // unlock
        press_release(KEY_TIMER, 2, 2'd1, 1'b0);                 // option 3 with blink
        // option 0 with time setting, reverse click while reversal busy
        press_release(KEY_TIMER | KEY_REVERSE, 3, OPT_TIMER, 1'b1);
        press_release(KEY_REVERSE, 4, OPT_NONE, 1'b0);           // reverse start
        // all three held into long press, release gives no click
        press_release(KEY_LOCK | KEY_TIMER | KEY_REVERSE, 7, OPT_TIMER, 1'b1);

        random_phase(300);

        // reset thresholds written back, with a long result hold-off
        set_config(10, 100, 1500, 3000);
        hold_asks <= hold_asks + 1;
        random_phase(400);

        // largest tick: timers saturate, no long window reachable
        set_config(1023, 0, 65535, 65535);
        random_phase(350);

        // zero tick: timers stand still while keys still mark pressed
        set_config(0, 0, 0, 65535);
        random_phase(100);

        // smallest nonzero tick with tight windows, no idling at all
        set_config(1, 2, 5, 8);
        quiet <= 1'b1;
        random_phase(300);
        quiet <= 1'b0;

        // long window narrower than one tick: it gets jumped over
        set_config(300, 250, 700, 800);
        hold_asks <= hold_asks + 1;
        random_phase(300);

        // short and long minimums at their largest, long maximum zero: no click or long press
        set_config(1000, 65535, 65535, 0);
        random_phase(100);

        wait_idle();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("[three_key_press_classifier_top] OK");
        else
            $display("[three_key_press_classifier_top] ERROR");
        $finish;
    end

endmodule
